### hdl/cafp_pkg.sv
package cafp_pkg;

  // Frame layout, by byte position counted from the sync byte
  localparam logic [3:0] PosLength    = 4'd1;
  localparam logic [3:0] PosType      = 4'd2;
  localparam logic [3:0] PosPitchHi   = 4'd3;
  localparam logic [3:0] PosPitchLo   = 4'd4;
  localparam logic [3:0] PosRollHi    = 4'd5;
  localparam logic [3:0] PosRollLo    = 4'd6;
  localparam logic [3:0] PosYawHi     = 4'd7;
  localparam logic [3:0] PosYawLo     = 4'd8;
  localparam logic [3:0] PosCrc       = 4'd9;
  localparam logic [3:0] PosMax       = 4'd15;

  localparam logic [7:0] LengthValue  = 8'd8;
  localparam logic [7:0] CrcPoly      = 8'hD5;
  localparam logic [7:0] AttTypeReset = 8'h1E;

  typedef enum logic [1:0] {
    StValid   = 2'd0,
    StLenErr  = 2'd1,
    StTypeErr = 2'd2,
    StCrcErr  = 2'd3
  } status_e;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
  } res_t;

  // One byte of CRC-8 DVB-S2, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

### hdl/cafp_if.sv
interface cafp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface cafp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] pitch;
  logic signed [15:0] roll;
  logic signed [15:0] yaw;

  modport source (output valid, output status, output pitch, output roll, output yaw,
                  input ready);
  modport sink (input valid, input status, input pitch, input roll, input yaw,
                output ready);
endinterface

### hdl/crsf_attitude_frame_parser.sv
// Attitude telemetry frame checker, CRC-8 DVB-S2 framing.
//
// Input channel in_i: one frame byte per request, starting with the sync
// byte; frame_end marks the final byte. Output channel out_o: one result
// per frame, raised for the request that carried frame_end. The result
// holds a status (length, type or CRC error by that priority, else valid),
// the big-endian pitch, roll and yaw, zeroed unless the frame is valid.
// Configuration: cfg_we_i writes cfg_data_i as the attitude frame type;
// write only while no frame is in flight.
//
// Throughput: one byte per cycle while in_i.ready is high. A byte's CRC
// step, field capture and the final checks sit between the frame-state
// registers and a two-entry result buffer, which registers each result.
// Stall: the result buffer holds two results; in_i.ready drops only while
// both entries wait on a stalled receiver, and rises as soon as one drains.
// Reset: frame state clears, the frame type returns to 0x1E and both result
// entries are dropped.
module crsf_attitude_frame_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  cafp_in_if.sink    in_i,
  cafp_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i
);
  import cafp_pkg::*;

  logic [7:0] frame_type_q;
  logic       acc;
  logic       push;
  logic       buf_ready;
  res_t       res;
  res_t       res_out;

  // Configured type byte that marks an attitude frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_type_q <= AttTypeReset;
    end else if (cfg_we_i) begin
      frame_type_q <= cfg_data_i;
    end
  end

  // A request is taken whenever the result buffer has room
  assign in_i.ready = buf_ready;
  assign acc        = in_i.valid & buf_ready;

  cafp_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .byte_i       (in_i.data_byte),
    .end_i        (in_i.frame_end),
    .frame_type_i (frame_type_q),
    .push_o       (push),
    .res_o        (res)
  );

  cafp_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .ready_o (buf_ready),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res_out)
  );

  assign out_o.status = res_out.status;
  assign out_o.pitch  = res_out.pitch;
  assign out_o.roll   = res_out.roll;
  assign out_o.yaw    = res_out.yaw;

endmodule

### hdl/cafp_tracker.sv
module cafp_tracker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  logic [7:0]     byte_i,
  input  logic           end_i,
  input  logic [7:0]     frame_type_i,
  output logic           push_o,
  output cafp_pkg::res_t res_o
);
  import cafp_pkg::*;

  logic [3:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] pitch_q, pitch_d;
  logic [15:0] roll_q, roll_d;
  logic [15:0] yaw_q, yaw_d;
  status_e     status;

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    len_d   = len_q;
    type_d  = type_q;
    pitch_d = pitch_q;
    roll_d  = roll_q;
    yaw_d   = yaw_q;

    if (pos_q == PosLength) len_d = byte_i;
    if (pos_q == PosType) type_d = byte_i;
    if (pos_q >= PosType && pos_q <= PosYawLo) crc_d = crc8_step(crc_q, byte_i);
    if (pos_q inside {PosPitchHi, PosPitchLo}) pitch_d = {pitch_q[7:0], byte_i};
    if (pos_q inside {PosRollHi, PosRollLo}) roll_d = {roll_q[7:0], byte_i};
    if (pos_q inside {PosYawHi, PosYawLo}) yaw_d = {yaw_q[7:0], byte_i};

    if (end_i) begin
      // Back to a clean slate; the next byte is a new sync byte
      pos_d   = '0;
      crc_d   = '0;
      len_d   = '0;
      type_d  = '0;
      pitch_d = '0;
      roll_d  = '0;
      yaw_d   = '0;
    end else if (pos_q != PosMax) begin
      pos_d = pos_q + 4'd1;
    end
  end

  // Length first, then type, then CRC
  always_comb begin
    if (pos_q != PosCrc || len_q != LengthValue) begin
      status = StLenErr;
    end else if (type_q != frame_type_i) begin
      status = StTypeErr;
    end else if (byte_i != crc_q) begin
      status = StCrcErr;
    end else begin
      status = StValid;
    end
  end

  assign push_o       = acc_i & end_i;
  assign res_o.status = status;
  assign res_o.pitch  = (status == StValid) ? pitch_q : '0;
  assign res_o.roll   = (status == StValid) ? roll_q : '0;
  assign res_o.yaw    = (status == StValid) ? yaw_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= '0;
      len_q   <= '0;
      type_q  <= '0;
      pitch_q <= '0;
      roll_q  <= '0;
      yaw_q   <= '0;
    end else if (acc_i) begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      len_q   <= len_d;
      type_q  <= type_d;
      pitch_q <= pitch_d;
      roll_q  <= roll_d;
      yaw_q   <= yaw_d;
    end
  end

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && end_i |=> pos_q == '0 && crc_q == '0)
    else $error("frame state not cleared after final byte");

  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !end_i && pos_q != PosMax |=> pos_q == $past(pos_q) + 4'd1)
    else $error("byte position did not advance");

  a_pos_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !end_i && pos_q == PosMax |=> pos_q == PosMax)
    else $error("byte position wrapped");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && res_o.status != StValid |-> res_o.pitch == '0 && res_o.roll == '0
      && res_o.yaw == '0)
    else $error("angles not zeroed on a rejected frame");
`endif

endmodule

### hdl/cafp_out_buf.sv
module cafp_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cafp_pkg::res_t res_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           ready_i,
  output cafp_pkg::res_t res_o
);
  import cafp_pkg::*;

  logic main_v_q, skid_v_q;
  res_t main_q, skid_q;
  logic pop;

  assign pop     = main_v_q & ready_i;
  assign valid_o = main_v_q;
  assign res_o   = main_q;
  assign ready_o = ~skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) skid_v_q <= 1'b0;
    end else if (push_i) begin
      if (main_v_q && !pop) skid_v_q <= 1'b1;
      else main_v_q <= 1'b1;
    end else if (pop) begin
      main_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) main_q <= skid_q;
    end else if (push_i) begin
      if (main_v_q && !pop) skid_q <= res_i;
      else main_q <= res_i;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry held without a main entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && skid_v_q))
    else $error("result pushed into a full buffer");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !pop |=> skid_v_q && $stable(skid_q))
    else $error("skid entry changed while waiting");
`endif

endmodule

### bench/tb_crsf_attitude_frame_parser.sv
module tb_crsf_attitude_frame_parser;
  import cafp_pkg::*;

  // Long receiver hold-off, enough to fill the two-entry result buffer and
  // push back on the byte channel for a good while
  localparam int unsigned HoldCycles   = 400;
  // Cycles to let pass after the last result before a register write or the end
  localparam int unsigned LatencySlack = 4;
  // Cycles without any accepted request before the run is abandoned
  localparam int unsigned StallLimit   = 2000;
  // Bytes per configuration phase in the random part
  localparam int unsigned PhaseBytes   = 290;

  // Predicts the result of each frame from the accepted bytes and holds the
  // results that are still due from the block, oldest first.
  class attitude_frame_model;
    res_t        due_results[$];
    logic [7:0]  frame_type;
    logic [3:0]  position;
    logic [7:0]  crc_acc;
    logic [7:0]  length_byte;
    logic [7:0]  type_byte;
    logic [15:0] pitch_acc;
    logic [15:0] roll_acc;
    logic [15:0] yaw_acc;
    int unsigned errors;

    function new();
      frame_type = AttTypeReset;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      position    = '0;
      crc_acc     = '0;
      length_byte = '0;
      type_byte   = '0;
      pitch_acc   = '0;
      roll_acc    = '0;
      yaw_acc     = '0;
    endfunction

    // CRC-8 DVB-S2, one data bit at a time, MSB first
    static function logic [7:0] crc8(logic [7:0] acc, logic [7:0] data);
      logic feedback;
      for (int i = 7; i >= 0; i--) begin
        feedback = acc[7] ^ data[i];
        acc      = {acc[6:0], 1'b0} ^ (feedback ? CrcPoly : 8'h00);
      end
      return acc;
    endfunction

    function void absorb_byte(logic [7:0] data, logic last);
      res_t due;
      if (position == PosLength) length_byte = data;
      if (position == PosType) type_byte = data;
      if (position >= PosType && position <= PosYawLo) crc_acc = crc8(crc_acc, data);
      if (position == PosPitchHi || position == PosPitchLo) pitch_acc = {pitch_acc[7:0], data};
      if (position == PosRollHi || position == PosRollLo) roll_acc = {roll_acc[7:0], data};
      if (position == PosYawHi || position == PosYawLo) yaw_acc = {yaw_acc[7:0], data};
      if (!last) begin
        if (position != PosMax) position++;
        return;
      end
      // Length first, then type, then CRC
      if (position != PosCrc || length_byte != LengthValue) due.status = StLenErr;
      else if (type_byte != frame_type) due.status = StTypeErr;
      else if (data != crc_acc) due.status = StCrcErr;
      else due.status = StValid;
      due.pitch = (due.status == StValid) ? pitch_acc : '0;
      due.roll  = (due.status == StValid) ? roll_acc : '0;
      due.yaw   = (due.status == StValid) ? yaw_acc : '0;
      due_results.push_back(due);
      restart();
    endfunction

    function void match_result(logic [1:0] status, logic signed [15:0] pitch,
                               logic signed [15:0] roll, logic signed [15:0] yaw);
      res_t due;
      if (due_results.size() == 0) begin
        $error("result with no frame outstanding: status %0d", status);
        errors++;
        return;
      end
      due = due_results.pop_front();
      if (status !== due.status) begin
        $error("status: expected %0d, got %0d", due.status, status);
        errors++;
      end
      if (pitch !== due.pitch) begin
        $error("pitch: expected %0d, got %0d", due.pitch, pitch);
        errors++;
      end
      if (roll !== due.roll) begin
        $error("roll: expected %0d, got %0d", due.roll, roll);
        errors++;
      end
      if (yaw !== due.yaw) begin
        $error("yaw: expected %0d, got %0d", due.yaw, yaw);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_data_i;

  cafp_in_if  in_if ();
  cafp_out_if out_if ();

  crsf_attitude_frame_parser DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  attitude_frame_model model = new();

  logic [7:0]  frame_q[$];   // bytes of the frame about to be sent
  int unsigned byte_count;   // accepted byte requests so far
  bit          calm;         // no idling on either side once set
  bit          hold_req;     // ask the receiver for one long hold-off

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sample both channels at the rising edge; values seen here are the ones
  // from before the edge, so acceptance is judged without races.
  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) model.absorb_byte(in_if.data_byte, in_if.frame_end);
    if (out_if.valid && out_if.ready)
      model.match_result(out_if.status, out_if.pitch, out_if.roll, out_if.yaw);
  end

  // Receiver: mostly ready, with random stall bursts, one long hold-off on
  // request, and no stalls at all once the run has gone calm.
  initial begin : receiver
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Abandon the run when neither channel has moved a request for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Offer one byte, sometimes after an idle burst, and hold it until taken.
  // Called at a rising edge; returns at the edge that accepted the request.
  task automatic push_byte(input logic [7:0] value, input logic last);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= value;
    in_if.frame_end <= last;
    do @(posedge clk_i); while (!in_if.ready);
    byte_count++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) push_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Drop valid and hold until every due result has come back; the first edge
  // lets the sampler take in the last accepted byte
  task automatic pause_until_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (model.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_frame_type(input logic [7:0] value);
    pause_until_drained();
    repeat (LatencySlack) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i         <= 1'b0;
    model.frame_type = value;
  endtask

  // Angles lean on the sign boundaries now and then
  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Build a ten-byte frame with a random sync byte and a correct CRC unless
  // asked to spoil it
  function automatic void make_frame(input logic [7:0] length_byte, input logic [7:0] type_byte,
                                     input logic [15:0] pitch, input logic [15:0] roll,
                                     input logic [15:0] yaw, input bit bad_crc);
    logic [7:0] crc;
    frame_q.delete();
    frame_q.push_back(8'($urandom_range(0, 255)));
    frame_q.push_back(length_byte);
    frame_q.push_back(type_byte);
    frame_q.push_back(pitch[15:8]);
    frame_q.push_back(pitch[7:0]);
    frame_q.push_back(roll[15:8]);
    frame_q.push_back(roll[7:0]);
    frame_q.push_back(yaw[15:8]);
    frame_q.push_back(yaw[7:0]);
    crc = 8'h00;
    for (int i = PosType; i <= PosYawLo; i++) crc = attitude_frame_model::crc8(crc, frame_q[i]);
    if (bad_crc) crc ^= 8'($urandom_range(1, 255));
    frame_q.push_back(crc);
  endfunction

  // Mostly well-formed frames with random angles; the rest carry one or
  // more faults, are cut short, run long, or are plain noise
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned keep;
    logic [7:0]  good_type;
    good_type = model.frame_type;
    pick      = $urandom_range(0, 99);
    if (pick < 58) begin
      make_frame(LengthValue, good_type, pick_angle(), pick_angle(), pick_angle(), 1'b0);
    end else if (pick < 66) begin
      make_frame(LengthValue, good_type, pick_angle(), pick_angle(), pick_angle(), 1'b1);
    end else if (pick < 74) begin
      make_frame(LengthValue, good_type ^ 8'($urandom_range(1, 255)),
                 pick_angle(), pick_angle(), pick_angle(), 1'($urandom_range(0, 1)));
    end else if (pick < 82) begin
      make_frame(LengthValue ^ 8'($urandom_range(1, 255)),
                 $urandom_range(0, 1) ? good_type : 8'($urandom_range(0, 255)),
                 pick_angle(), pick_angle(), pick_angle(), 1'($urandom_range(0, 1)));
    end else if (pick < 90) begin
      // Short frame: end before the CRC byte
      make_frame(LengthValue, good_type, pick_angle(), pick_angle(), pick_angle(), 1'b0);
      keep = $urandom_range(1, 9);
      while (frame_q.size() > keep) void'(frame_q.pop_back());
    end else if (pick < 95) begin
      // Long frame: trailing bytes, at times far enough to saturate the byte counter
      make_frame(LengthValue, good_type, pick_angle(), pick_angle(), pick_angle(), 1'b0);
      repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      frame_q.delete();
      repeat ($urandom_range(1, 14)) frame_q.push_back(8'($urandom_range(0, 255)));
    end
    send_frame();
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    logic [7:0]  phase_type;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_data_i       = 8'h00;
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.frame_end  = 1'b0;
    out_if.ready     = 1'b0;
    byte_count       = 0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset frame type
    // Frame that ends on its sync byte: length error
    frame_q.delete();
    frame_q.push_back(8'hC8);
    send_frame();
    // Valid frame with the angle extremes
    make_frame(LengthValue, AttTypeReset, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0);
    send_frame();
    // Every fault at once: the length error must win
    make_frame(8'hFF, 8'h00, 16'hFFFF, 16'h0000, 16'h7FFF, 1'b1);
    send_frame();

    // Random part, in phases at different frame types
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       phase_type = 8'h00;
        1:       phase_type = 8'hFF;
        3:       phase_type = AttTypeReset;
        default: phase_type = 8'($urandom_range(0, 255));
      endcase
      write_frame_type(phase_type);
      phase_end = byte_count + PhaseBytes;
      if (phase == 1) begin
        // Stall the receiver while bytes keep coming, to back up the buffer
        repeat (3) send_random_frame();
        hold_req = 1'b1;
      end
      if (phase == 2) begin
        repeat (5) send_random_frame();
        pause_until_drained();
      end
      while (byte_count < phase_end) begin
        if (phase == 4 && byte_count + PhaseBytes / 2 >= phase_end) calm = 1'b1;
        send_random_frame();
      end
    end

    pause_until_drained();
    repeat (LatencySlack) @(posedge clk_i);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
